FILE: src/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Types, codes and byte-lane helpers shared by the boot memory map parser.
// ----------------------------------------------------------------------------
package bmm_pkg;

  localparam int MAX_ENTRIES_DEF = 32;

  localparam logic       KIND_REGION = 1'b0;
  localparam logic       KIND_FINISH = 1'b1;

  localparam logic [1:0] STATUS_END_TAG   = 2'd0;
  localparam logic [1:0] STATUS_TOTAL     = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  localparam logic [31:0] TAG_END       = 32'd0;
  localparam logic [31:0] TAG_MMAP      = 32'd6;
  localparam logic [31:0] REGION_RAM    = 32'd1;
  localparam logic [31:0] HDR_LAST      = 32'd7;
  localparam logic [31:0] TAG_MIN_SIZE  = 32'd8;
  localparam logic [31:0] ENTRY_MIN     = 32'd20;
  localparam logic [31:0] ENTRY_LAST    = 32'd19;
  localparam logic [31:0] ENTRY_START   = 32'd16;
  localparam logic [32:0] ALIGN_ADD     = 33'd7;
  localparam logic [32:0] ALIGN_MASK    = ~33'd7;
  localparam logic [5:0]  COUNT_SAT     = 6'd63;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_TAG,
    PH_PENDING,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [4:0]  entry_index;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [31:0] region_type;
    logic [63:0] available_total;
    logic [5:0]  entry_count;
    logic [1:0]  end_status;
  } result_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [31:0] put_byte32(input logic [31:0] w, input logic [1:0] slot,
                                             input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[slot*8 +: 8] = b;
    return r;
  endfunction

  function automatic logic [63:0] put_byte64(input logic [63:0] w, input logic [2:0] slot,
                                             input logic [7:0] b);
    logic [63:0] r;
    r = w;
    r[slot*8 +: 8] = b;
    return r;
  endfunction

endpackage

FILE: src/bmm_stream_if.sv
// ----------------------------------------------------------------------------
// bmm_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface bmm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/bmm_core.sv
// ----------------------------------------------------------------------------
// bmm_core
// Parse state, one-beat step logic and the result register.
// ----------------------------------------------------------------------------
module bmm_core
  import bmm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  item_t               item,
  output logic                advance,
  bmm_stream_if.source        result
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  phase_t             phase, phase_next;
  logic [31:0]        blk_off, blk_off_next;
  logic [31:0]        blk_total, blk_total_next;
  logic [31:0]        tag_kind, tag_kind_next;
  logic [31:0]        tag_size, tag_size_next;
  logic [31:0]        tag_off, tag_off_next;
  logic [31:0]        ent_stride, ent_stride_next;
  logic [31:0]        ent_off, ent_off_next;
  logic [63:0]        f_base, f_base_next;
  logic [63:0]        f_len, f_len_next;
  logic [31:0]        f_type, f_type_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [63:0]        ram_sum, ram_sum_next;

  logic               emit;
  result_t            res;
  logic               out_valid;
  result_t            out_data;

  function automatic logic [5:0] count_out(input logic [CNT_W-1:0] c);
    return (32'(c) > 32'(COUNT_SAT)) ? COUNT_SAT : 6'(c);
  endfunction

  assign advance = item_valid && (!out_valid || result.ready);

  always_comb begin
    logic [31:0] rel;
    logic [31:0] cur;
    logic [31:0] pos;
    logic [32:0] stride8;
    logic        stop;

    phase_next      = phase;
    blk_off_next    = blk_off;
    blk_total_next  = blk_total;
    tag_kind_next   = tag_kind;
    tag_size_next   = tag_size;
    tag_off_next    = tag_off;
    ent_stride_next = ent_stride;
    ent_off_next    = ent_off;
    f_base_next     = f_base;
    f_len_next      = f_len;
    f_type_next     = f_type;
    count_next      = count;
    ram_sum_next    = ram_sum;
    emit            = 1'b0;
    res             = '0;
    rel             = tag_off;
    cur             = blk_off;
    pos             = ent_off;
    stride8         = '0;
    stop            = 1'b0;

    if (phase == PH_PENDING) begin
      emit                = 1'b1;
      res.result_kind     = KIND_FINISH;
      res.available_total = ram_sum;
      res.entry_count     = count_out(count);
      res.end_status      = STATUS_TOTAL;
      phase_next          = PH_DONE;
    end

    if (item.first_byte) begin
      blk_off_next    = '0;
      blk_total_next  = '0;
      tag_kind_next   = '0;
      tag_size_next   = '0;
      tag_off_next    = '0;
      ent_stride_next = '0;
      ent_off_next    = '0;
      f_base_next     = '0;
      f_len_next      = '0;
      f_type_next     = '0;
      count_next      = '0;
      ram_sum_next    = '0;
      phase_next      = PH_HEADER;
    end

    if (phase_next == PH_HEADER) begin
      cur = blk_off_next;
      if (cur < 32'd4) begin
        blk_total_next = put_byte32(blk_total_next, cur[1:0], item.data_byte);
      end
      blk_off_next = sat_inc32(cur);
      if (cur == HDR_LAST) begin
        if (TAG_MIN_SIZE >= blk_total_next) begin
          emit                = 1'b1;
          res                 = '0;
          res.result_kind     = KIND_FINISH;
          res.available_total = ram_sum_next;
          res.entry_count     = count_out(count_next);
          res.end_status      = STATUS_TOTAL;
          phase_next          = PH_DONE;
        end else begin
          phase_next   = PH_TAG;
          tag_off_next = '0;
          ent_off_next = '0;
        end
      end
    end else if (phase_next == PH_TAG) begin
      blk_off_next = sat_inc32(cur);
      if (rel < 32'd4) begin
        tag_kind_next = put_byte32(tag_kind, rel[1:0], item.data_byte);
        if (rel == 32'd3 && tag_kind_next == TAG_END) begin
          emit                = 1'b1;
          res.result_kind     = KIND_FINISH;
          res.available_total = ram_sum;
          res.entry_count     = count_out(count);
          res.end_status      = STATUS_END_TAG;
          phase_next          = PH_DONE;
          stop                = 1'b1;
        end
      end else if (rel < 32'd8) begin
        tag_size_next = put_byte32(tag_size, rel[1:0], item.data_byte);
        if (rel == HDR_LAST && tag_size_next < TAG_MIN_SIZE) begin
          emit                = 1'b1;
          res.result_kind     = KIND_FINISH;
          res.available_total = ram_sum;
          res.entry_count     = count_out(count);
          res.end_status      = STATUS_MALFORMED;
          phase_next          = PH_DONE;
          stop                = 1'b1;
        end
      end else if (rel < 32'd12) begin
        if (tag_kind == TAG_MMAP) begin
          ent_stride_next = put_byte32(ent_stride, rel[1:0], item.data_byte);
        end
      end else if (rel >= ENTRY_START && tag_kind == TAG_MMAP) begin
        if (pos < 32'd8) begin
          f_base_next = put_byte64(f_base, pos[2:0], item.data_byte);
        end else if (pos < 32'd16) begin
          f_len_next = put_byte64(f_len, pos[2:0], item.data_byte);
        end else if (pos < ENTRY_MIN) begin
          f_type_next = put_byte32(f_type, pos[1:0], item.data_byte);
        end
        if (pos == ENTRY_LAST && ent_stride >= ENTRY_MIN &&
            32'(count) < 32'(MAX_ENTRIES) && (rel - ENTRY_LAST) < tag_size) begin
          ram_sum_next        = (f_type_next == REGION_RAM) ? ram_sum + f_len : ram_sum;
          count_next          = CNT_W'(count + 1'b1);
          emit                = 1'b1;
          res.result_kind     = KIND_REGION;
          res.entry_index     = 5'(count);
          res.region_base     = f_base;
          res.region_length   = f_len;
          res.region_type     = f_type_next;
          res.available_total = ram_sum_next;
          res.entry_count     = count_out(count_next);
          res.end_status      = STATUS_END_TAG;
        end
        ent_off_next = ({1'b0, pos} + 33'd1 == {1'b0, ent_stride}) ? '0 : sat_inc32(pos);
      end

      if (!stop) begin
        stride8 = ({1'b0, tag_size_next} + ALIGN_ADD) & ALIGN_MASK;
        if (rel >= HDR_LAST && {1'b0, rel} + 33'd1 == stride8) begin
          if ({1'b0, cur} + 33'd1 >= {1'b0, blk_total}) begin
            if (emit) begin
              phase_next = PH_PENDING;
            end else begin
              emit                = 1'b1;
              res.result_kind     = KIND_FINISH;
              res.available_total = ram_sum;
              res.entry_count     = count_out(count);
              res.end_status      = STATUS_TOTAL;
              phase_next          = PH_DONE;
            end
          end else begin
            tag_off_next    = '0;
            ent_off_next    = '0;
            tag_kind_next   = '0;
            tag_size_next   = '0;
            ent_stride_next = '0;
          end
        end else begin
          tag_off_next = sat_inc32(rel);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      blk_off    <= '0;
      blk_total  <= '0;
      tag_kind   <= '0;
      tag_size   <= '0;
      tag_off    <= '0;
      ent_stride <= '0;
      ent_off    <= '0;
      f_base     <= '0;
      f_len      <= '0;
      f_type     <= '0;
      count      <= '0;
      ram_sum    <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      blk_off    <= blk_off_next;
      blk_total  <= blk_total_next;
      tag_kind   <= tag_kind_next;
      tag_size   <= tag_size_next;
      tag_off    <= tag_off_next;
      ent_stride <= ent_stride_next;
      ent_off    <= ent_off_next;
      f_base     <= f_base_next;
      f_len      <= f_len_next;
      f_type     <= f_type_next;
      count      <= count_next;
      ram_sum    <= ram_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= res;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_data;

endmodule

FILE: src/boot_memory_map_parser.sv
// ----------------------------------------------------------------------------
// boot_memory_map_parser
// Streaming parser for the memory map tag of a boot-information block.
//
//   channel  dir  beat                          payload
//   stream   in   one block byte                data_byte, first_byte
//   result   out  one captured region or finish kind, index, base, length,
//                                               type, total, count, status
//
// One byte per cycle while the result channel does not stall; a byte is held in
// the input register and any result it gives is registered in the output register.
// The step logic advances whenever a byte is held and the output register is empty or drained.
// Reset is synchronous and returns the parser to idle, waiting for first_byte.
// A stalled result holds the step; the input register holds one byte and
// stream ready drops until the result drains.
// ----------------------------------------------------------------------------
module boot_memory_map_parser
  import bmm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  bmm_stream_if.sink   stream,
  bmm_stream_if.source result
);

  logic  item_valid;
  item_t item;
  logic  advance;

  assign stream.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (stream.ready) begin
      item_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      item <= stream.payload;
    end
  end

  bmm_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item      (item),
    .advance   (advance),
    .result    (result)
  );

endmodule

FILE: src/bmm_checker.sv
// ----------------------------------------------------------------------------
// bmm_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bmm_checker
  import bmm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result_payload
);

  localparam logic [5:0] CNT_CAP = (MAX_ENTRIES > 63) ? 6'd63 : 6'(MAX_ENTRIES);

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_payload.result_kind == KIND_FINISH |->
      result_payload.region_base == '0 && result_payload.region_length == '0 &&
      result_payload.region_type == '0 && result_payload.entry_index == '0)
    else $error("finish beat carries region data");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_payload.result_kind == KIND_REGION |->
      result_payload.end_status == STATUS_END_TAG && result_payload.entry_count != '0)
    else $error("region beat with bad status or count");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_payload.entry_count <= CNT_CAP &&
      result_payload.end_status != 2'd3)
    else $error("count beyond capacity or bad status code");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_payload))
    else $error("stalled result beat changed");

endmodule

bind boot_memory_map_parser bmm_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_bmm_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_payload(result.payload)
);
